FILE: rtl/core/mpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_pkg: shared types and constants for the min priority queue
// Entry layout, opcodes, status codes, controller states and memory port.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int unsigned DEPTH = 8;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [31:0] rank;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    status_e status;
    entry_t  entry;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

FILE: rtl/core/mpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_ram: entry store
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module mpq_ram (
  input  wire logic              clk_i,
  input  wire mpq_pkg::mem_req_t req_i,
  output mpq_pkg::entry_t        rdata_o
);
  import mpq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/core/mpq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_ctrl: queue sequencer
// Appends on insert; on remove scans the store for the smallest rank, then
// shifts the later entries down one place to keep insertion order.
// ----------------------------------------------------------------------------
module mpq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire mpq_pkg::opcode_e  in_op_i,
  input  wire mpq_pkg::entry_t   in_entry_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output mpq_pkg::result_t       res_o,
  output mpq_pkg::mem_req_t      mem_req_o,
  input  wire mpq_pkg::entry_t   mem_rdata_i
);
  import mpq_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  entry_t           best_q, best_d;
  result_t          res_q, res_d;

  logic [CNT_W-1:0] cnt_m1;
  logic             take;
  entry_t           cur_best;
  logic [IDX_W-1:0] cur_idx;

  assign cnt_m1 = cnt_q - 1'b1;

  // first entry seeds the scan; strict less keeps the earliest on ties
  assign take     = (idx_q == '0) || ($signed(mem_rdata_i.rank) < $signed(best_q.rank));
  assign cur_best = take ? mem_rdata_i : best_q;
  assign cur_idx  = take ? idx_q : best_idx_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    res_d      = res_q;
    mem_req_o  = '0;
    in_ready_o = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d.entry = '0;
          if (in_op_i == OP_INSERT) begin
            if (cnt_q == CNT_W'(DEPTH)) begin
              res_d.status = ST_FULL;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = cnt_q[IDX_W-1:0];
              mem_req_o.wdata = in_entry_i;
              cnt_d           = cnt_q + 1'b1;
              res_d.status    = ST_INSERTED;
            end
            state_d = S_DONE;
          end else if (cnt_q == '0) begin
            res_d.status = ST_EMPTY;
            state_d      = S_DONE;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = '0;
            idx_d           = '0;
            state_d         = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        best_d     = cur_best;
        best_idx_d = cur_idx;
        if (CNT_W'(idx_q) == cnt_m1) begin
          if (CNT_W'(cur_idx) == cnt_m1) begin
            // winner is the tail entry: nothing to move
            cnt_d       = cnt_m1;
            res_d.status = ST_REMOVED;
            res_d.entry  = cur_best;
            state_d      = S_DONE;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = cur_idx + 1'b1;
            idx_d           = cur_idx + 1'b1;
            state_d         = S_SHIFT;
          end
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_q + 1'b1;
          idx_d           = idx_q + 1'b1;
        end
      end
      S_SHIFT: begin
        // data of entry idx moves to idx-1; next read runs ahead by two
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q - 1'b1;
        mem_req_o.wdata = mem_rdata_i;
        if (CNT_W'(idx_q) == cnt_m1) begin
          cnt_d        = cnt_m1;
          res_d.status = ST_REMOVED;
          res_d.entry  = best_q;
          state_d      = S_DONE;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_q + 1'b1;
          idx_d           = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
  end

  // ---- assertions ----
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_SHIFT) |-> (CNT_W'(idx_q) < cnt_q))
    else $error("scan or shift index beyond valid entries");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> (state_q == S_IDLE || state_q == S_SHIFT))
    else $error("store written outside insert or shift");

  a_shift_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.we && mem_req_o.re) |-> (mem_req_o.waddr != mem_req_o.raddr))
    else $error("read and write hit the same entry");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && state_d == S_DONE) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("remove did not drop count by one");

endmodule
`default_nettype wire

FILE: rtl/core/min_priority_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Insert: the store write is issued with the request; the status then goes
//   through S_DONE to the output register. Remove: min scan, then shift walk.
// Throughput: one request in flight; set by the single read port of the
//   entry store, which the min scan and the shift walk one entry per cycle.
// Reset: entry count, sequencer state and output valid clear; entries stay.
// ----------------------------------------------------------------------------
// min_priority_queue_unit: bounded stable min priority queue
// Stream front end with output register around the sequencer and store.
// ----------------------------------------------------------------------------
module min_priority_queue_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,  // [31:0] in_value, [63:32] in_rank
  input  wire logic [0:0]  s_axis_tuser_i,  // [0] opcode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,  // [31:0] out_value, [63:32] out_rank
  output logic [1:0]       m_axis_tuser_o   // [1:0] status
);
  import mpq_pkg::*;

  entry_t   in_entry;
  opcode_e  in_op;
  logic     res_valid, res_ready;
  result_t  res;
  mem_req_t mem_req;
  entry_t   mem_rdata;

  logic     m_valid_q;
  result_t  m_res_q;

  assign in_entry.value = s_axis_tdata_i[31:0];
  assign in_entry.rank  = s_axis_tdata_i[63:32];
  assign in_op          = opcode_e'(s_axis_tuser_i[0]);

  mpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (in_op),
    .in_entry_i  (in_entry),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  mpq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_res_q.entry.rank, m_res_q.entry.value};
  assign m_axis_tuser_o  = m_res_q.status;

endmodule
`default_nettype wire
